>>> hw/rtl/twt_pkg.sv
// ----------------------------------------------------------------------------
// twt_pkg
// Shared constants, word types and controller/datapath signal groups for the
// trapped water total block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package twt_pkg;

	localparam int MAX_COLUMNS = 1024;
	localparam int HEIGHT_BITS = 16;

	localparam int IN_HEIGHT_BITS = 16;
	localparam int TOTAL_BITS     = 26;

	localparam int ADDR_BITS  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int COUNT_BITS = $clog2(MAX_COLUMNS + 1);

	// accumulator holds the worst case sum and at least one bit past the output
	localparam int SUM_RAW_BITS = ADDR_BITS + HEIGHT_BITS + 1;
	localparam int SUM_BITS     = (SUM_RAW_BITS > TOTAL_BITS) ? SUM_RAW_BITS : TOTAL_BITS + 1;

	localparam int RAM_WIDTH = 2 * HEIGHT_BITS;

	typedef struct packed {
		logic [IN_HEIGHT_BITS-1:0] height;
		logic                      last;
	} in_word_t;

	typedef struct packed {
		logic [TOTAL_BITS-1:0] total_water;
		logic                  overflow;
	} out_word_t;

	typedef struct packed {
		logic load;    // take the accepted column
		logic scan_rd; // issue one backward read
		logic finish;  // publish the total and clear the sequence
	} twt_cmd_t;

	typedef struct packed {
		logic ptr_zero; // no stored column left to read
		logic busy;     // a read or an add is still in flight
		logic out_free; // output register can take a word this cycle
	} twt_status_t;

	function automatic logic [HEIGHT_BITS-1:0] mask_height(input logic [IN_HEIGHT_BITS-1:0] h);
		logic [HEIGHT_BITS+IN_HEIGHT_BITS-1:0] wide;
		wide = {{HEIGHT_BITS{1'b0}}, h};
		return wide[HEIGHT_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/twt_ram.sv
// ----------------------------------------------------------------------------
// twt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module twt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                           wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> hw/rtl/twt_datapath.sv
// ----------------------------------------------------------------------------
// twt_datapath
// Column store, left and right running maxima, water accumulator and the
// output word register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module twt_datapath (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire twt_pkg::in_word_t   item,
	input  wire twt_pkg::twt_cmd_t   cmd,
	output twt_pkg::twt_status_t     status,
	output logic                     result_valid,
	input  wire logic                result_stall,
	output twt_pkg::out_word_t       result
);

	logic [twt_pkg::COUNT_BITS-1:0]  count_q;
	logic [twt_pkg::HEIGHT_BITS-1:0] left_max_q;
	logic [twt_pkg::HEIGHT_BITS-1:0] right_max_q;
	logic [twt_pkg::SUM_BITS-1:0]    sum_q;
	logic                            dropped_q;

	logic                            rd_valid_s1;
	logic                            diff_valid_s2;
	logic [twt_pkg::HEIGHT_BITS-1:0] diff_s2;

	logic                            out_valid_q;
	twt_pkg::out_word_t              out_word_q;

	logic [twt_pkg::HEIGHT_BITS-1:0] h_in;
	logic [twt_pkg::HEIGHT_BITS-1:0] left_next;
	logic                            has_room;
	logic                            ram_we;
	logic [twt_pkg::ADDR_BITS-1:0]   ram_waddr;
	logic [twt_pkg::ADDR_BITS-1:0]   ram_raddr;
	logic [twt_pkg::COUNT_BITS-1:0]  count_dec;
	logic [twt_pkg::RAM_WIDTH-1:0]   ram_wdata;
	logic [twt_pkg::RAM_WIDTH-1:0]   ram_rdata;

	logic [twt_pkg::HEIGHT_BITS-1:0] rd_height;
	logic [twt_pkg::HEIGHT_BITS-1:0] rd_left;
	logic [twt_pkg::HEIGHT_BITS-1:0] right_next;
	logic [twt_pkg::HEIGHT_BITS-1:0] level;
	logic [twt_pkg::TOTAL_BITS-1:0]  total_sat;

	assign h_in      = twt_pkg::mask_height(item.height);
	assign left_next = (h_in > left_max_q) ? h_in : left_max_q;
	assign has_room  = count_q < twt_pkg::COUNT_BITS'(twt_pkg::MAX_COLUMNS);
	assign ram_we    = cmd.load && has_room;
	assign ram_waddr = count_q[twt_pkg::ADDR_BITS-1:0];
	assign ram_wdata = {h_in, left_next};
	assign count_dec = count_q - twt_pkg::COUNT_BITS'(1);
	assign ram_raddr = count_dec[twt_pkg::ADDR_BITS-1:0];

	twt_ram #(
		.WIDTH(twt_pkg::RAM_WIDTH),
		.DEPTH(twt_pkg::MAX_COLUMNS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// water at one position: min(left max, right max) - height
	assign rd_height  = ram_rdata[twt_pkg::RAM_WIDTH-1:twt_pkg::HEIGHT_BITS];
	assign rd_left    = ram_rdata[twt_pkg::HEIGHT_BITS-1:0];
	assign right_next = (rd_height > right_max_q) ? rd_height : right_max_q;
	assign level      = (rd_left < right_next) ? rd_left : right_next;

	assign total_sat = (sum_q > twt_pkg::SUM_BITS'({twt_pkg::TOTAL_BITS{1'b1}}))
		? {twt_pkg::TOTAL_BITS{1'b1}} : sum_q[twt_pkg::TOTAL_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			left_max_q    <= '0;
			right_max_q   <= '0;
			sum_q         <= '0;
			dropped_q     <= 1'b0;
			rd_valid_s1   <= 1'b0;
			diff_valid_s2 <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			rd_valid_s1   <= cmd.scan_rd;
			diff_valid_s2 <= rd_valid_s1;

			if (cmd.finish) begin
				count_q     <= '0;
				left_max_q  <= '0;
				right_max_q <= '0;
				sum_q       <= '0;
				dropped_q   <= 1'b0;
			end else begin
				if (cmd.load) begin
					if (has_room) begin
						count_q    <= count_q + twt_pkg::COUNT_BITS'(1);
						left_max_q <= left_next;
					end else begin
						dropped_q <= 1'b1;
					end
				end else if (cmd.scan_rd) begin
					count_q <= count_dec;
				end
				if (rd_valid_s1) begin
					right_max_q <= right_next;
				end
				if (diff_valid_s2) begin
					sum_q <= sum_q + twt_pkg::SUM_BITS'(diff_s2);
				end
			end

			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_valid_s1) begin
			diff_s2 <= level - rd_height;
		end
		if (cmd.finish) begin
			out_word_q.total_water <= total_sat;
			out_word_q.overflow    <= dropped_q;
		end
	end

	assign status.ptr_zero = (count_q == '0);
	assign status.busy     = rd_valid_s1 || diff_valid_s2;
	assign status.out_free = !out_valid_q || !result_stall;

	assign result_valid = out_valid_q;
	assign result       = out_word_q;

endmodule

`default_nettype wire

>>> hw/rtl/twt_ctrl.sv
// ----------------------------------------------------------------------------
// twt_ctrl
// Sequencer: loads columns, runs the backward pass, then hands the total to
// the output register and restarts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module twt_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	input  wire logic                  item_last,
	output logic                       item_stall,
	output twt_pkg::twt_cmd_t          cmd,
	input  wire twt_pkg::twt_status_t  status
);

	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       take;

	assign item_stall = (state_q != ST_LOAD);
	assign take       = item_valid && !item_stall;

	always_comb begin
		state_d     = state_q;
		cmd.load    = 1'b0;
		cmd.scan_rd = 1'b0;
		cmd.finish  = 1'b0;
		case (state_q)
			ST_LOAD: begin
				if (take) begin
					cmd.load = 1'b1;
					if (item_last) begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (!status.ptr_zero) begin
					cmd.scan_rd = 1'b1;
				end else if (!status.busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// wait for room in the output register
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/trapped_water_total.sv
// ----------------------------------------------------------------------------
// trapped_water_total
// Sums the rain water trapped over a sequence of column heights and returns
// one total per sequence, with a flag for columns dropped when the store was
// full.
//
//   channel | direction | handshake                  | word
//   --------+-----------+----------------------------+-------------------------
//   item    | in        | item_valid / item_stall    | height, last
//   result  | out       | result_valid / result_stall| total_water, overflow
//
// While loading, a column is taken in every cycle that item_valid is high.
// The backward pass then reads the store once per stored column, through the
// RAM read and difference registers into the sum, and publishes the total.
// No column is taken from the backward pass until the total is published.
// The output register lets loading of the next sequence start while the
// previous total is still stalled. Reset needs no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trapped_water_total (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire twt_pkg::in_word_t  item,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output twt_pkg::out_word_t      result
);

	twt_pkg::twt_cmd_t    cmd;
	twt_pkg::twt_status_t status;

	twt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_last  (item.last),
		.item_stall (item_stall),
		.cmd        (cmd),
		.status     (status)
	);

	twt_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.status       (status),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire
